// File: rtl/core/ellipsoid_shell_pixel_classifier_assert.svh
// Assertion macros used by the classifier top level
`ifndef ELLIPSOID_SHELL_PIXEL_CLASSIFIER_ASSERT_SVH
`define ELLIPSOID_SHELL_PIXEL_CLASSIFIER_ASSERT_SVH

// Check a condition at every rising clock edge outside reset
`define ESP_ASSERT(lbl, clk, rst, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Check that a condition implies another one in the same cycle
`define ESP_ASSERT_IMP(lbl, clk, rst, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error(msg);

`endif

// File: rtl/core/esp_pkg.sv
// Shared types, codes and constants of the ellipsoid shell pixel classifier
`timescale 1ns / 1ps

package esp_pkg;

  localparam int PIX_W        = 13;
  localparam int FRAME_W      = 16;
  localparam int COORD_W      = 16;
  localparam int SLICE_W      = 21;
  localparam int REG_W        = 63;
  localparam int RAD_W        = 16;
  localparam int SQ_W         = 32;
  localparam int D_W          = 25;
  localparam int PROD_W       = D_W + SLICE_W;
  localparam int ACC_W        = PROD_W + 2;
  localparam int W_W          = ACC_W - 16;
  localparam int Q_W          = D_W + W_W;
  localparam int RR_W         = Q_W + 2;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 64;
  localparam int PIXEL_BITS_DEF = 13;

  localparam logic [RAD_W-1:0] PEAK_RST  = 16'd768;
  localparam logic [RAD_W-1:0] INNER_RST = 16'd768;
  localparam logic [RAD_W-1:0] OUTER_RST = 16'd1536;
  localparam logic [SQ_W-1:0]  FIXED_PEAK_SQ = 32'd65536;

  localparam logic [1:0] CLS_EXCLUDED   = 2'd0;
  localparam logic [1:0] CLS_BACKGROUND = 2'd1;
  localparam logic [1:0] CLS_FORBIDDEN  = 2'd2;
  localparam logic [1:0] CLS_PEAK       = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_CENTRE     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_METRIC_DIA = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_METRIC_CRS = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PEAK_RAD   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_INNER_RAD  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_OUTER_RAD  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_FIXED_MODE = 3'd6;

  typedef struct packed {
    logic [PIX_W-1:0]   pixel_x;
    logic [PIX_W-1:0]   pixel_y;
    logic [FRAME_W-1:0] frame_index;
    logic [1:0]         mask_in;
  } in_item_t;

  typedef struct packed {
    logic [1:0] region_class;
    logic [1:0] mask_out;
    logic       accept;
  } out_item_t;

  typedef struct packed {
    logic [REG_W-1:0] centre;
    logic [REG_W-1:0] metric_dia;
    logic [REG_W-1:0] metric_crs;
    logic [SQ_W-1:0]  peak_sq;
    logic [SQ_W-1:0]  inner_sq;
    logic [SQ_W-1:0]  outer_sq;
    logic             fixed_mode;
  } cfg_t;

endpackage

// File: rtl/core/esp_cfg.sv
// Configuration registers and squared radii
`timescale 1ns / 1ps

module esp_cfg (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            wr_en,
  input  logic [esp_pkg::CFG_IDX_W-1:0]   wr_index,
  input  logic [esp_pkg::CFG_DATA_W-1:0]  wr_data,
  output esp_pkg::cfg_t                   cfg
);

  localparam logic [esp_pkg::SQ_W-1:0] PEAK_SQ_RST =
    esp_pkg::SQ_W'(esp_pkg::PEAK_RST) * esp_pkg::SQ_W'(esp_pkg::PEAK_RST);
  localparam logic [esp_pkg::SQ_W-1:0] INNER_SQ_RST =
    esp_pkg::SQ_W'(esp_pkg::INNER_RST) * esp_pkg::SQ_W'(esp_pkg::INNER_RST);
  localparam logic [esp_pkg::SQ_W-1:0] OUTER_SQ_RST =
    esp_pkg::SQ_W'(esp_pkg::OUTER_RST) * esp_pkg::SQ_W'(esp_pkg::OUTER_RST);

  logic [esp_pkg::RAD_W-1:0] peak_rad;
  logic [esp_pkg::RAD_W-1:0] inner_rad;
  logic [esp_pkg::RAD_W-1:0] outer_rad;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.centre     <= '0;
      cfg.metric_dia <= '0;
      cfg.metric_crs <= '0;
      cfg.fixed_mode <= 1'b0;
      peak_rad       <= esp_pkg::PEAK_RST;
      inner_rad      <= esp_pkg::INNER_RST;
      outer_rad      <= esp_pkg::OUTER_RST;
      cfg.peak_sq    <= PEAK_SQ_RST;
      cfg.inner_sq   <= INNER_SQ_RST;
      cfg.outer_sq   <= OUTER_SQ_RST;
    end else begin
      // squares follow the radius registers in the next cycle
      cfg.peak_sq  <= esp_pkg::SQ_W'(peak_rad) * esp_pkg::SQ_W'(peak_rad);
      cfg.inner_sq <= esp_pkg::SQ_W'(inner_rad) * esp_pkg::SQ_W'(inner_rad);
      cfg.outer_sq <= esp_pkg::SQ_W'(outer_rad) * esp_pkg::SQ_W'(outer_rad);
      if (wr_en) begin
        case (wr_index)
          esp_pkg::REG_CENTRE:     cfg.centre     <= wr_data[esp_pkg::REG_W-1:0];
          esp_pkg::REG_METRIC_DIA: cfg.metric_dia <= wr_data[esp_pkg::REG_W-1:0];
          esp_pkg::REG_METRIC_CRS: cfg.metric_crs <= wr_data[esp_pkg::REG_W-1:0];
          esp_pkg::REG_PEAK_RAD:   peak_rad       <= wr_data[esp_pkg::RAD_W-1:0];
          esp_pkg::REG_INNER_RAD:  inner_rad      <= wr_data[esp_pkg::RAD_W-1:0];
          esp_pkg::REG_OUTER_RAD:  outer_rad      <= wr_data[esp_pkg::RAD_W-1:0];
          esp_pkg::REG_FIXED_MODE: cfg.fixed_mode <= wr_data[0];
          default: ;
        endcase
      end
    end
  end

endmodule

// File: rtl/core/esp_quad.sv
// Five-stage pipeline for the offset and the quadratic form d'Md
`timescale 1ns / 1ps

module esp_quad #(
  parameter int PIXEL_BITS = esp_pkg::PIXEL_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             en,
  input  logic                             in_valid,
  input  esp_pkg::in_item_t                in_item,
  input  esp_pkg::cfg_t                    cfg,
  output logic                             rr_valid,
  output logic signed [esp_pkg::RR_W-1:0]  rr,
  output logic [1:0]                       rr_mask
);

  localparam int XB = (PIXEL_BITS < esp_pkg::PIX_W) ? PIXEL_BITS : esp_pkg::PIX_W;
  localparam int SW = esp_pkg::SLICE_W;

  logic [esp_pkg::COORD_W-1:0] coord [3];
  logic signed [SW-1:0]        m [3][3];

  logic                                 v1, v2, v3, v4;
  logic [1:0]                           mk1, mk2, mk3, mk4;
  logic signed [esp_pkg::D_W-1:0]       d1 [3];
  logic signed [esp_pkg::D_W-1:0]       d2 [3];
  logic signed [esp_pkg::D_W-1:0]       d3 [3];
  logic signed [esp_pkg::PROD_W-1:0]    prod [9];
  logic signed [esp_pkg::ACC_W-1:0]     acc [3];
  logic signed [esp_pkg::W_W-1:0]       w3 [3];
  logic signed [esp_pkg::Q_W-1:0]       q4 [3];
  logic signed [esp_pkg::D_W-1:0]       d_next [3];

  always_comb begin
    coord[0] = esp_pkg::COORD_W'(in_item.pixel_x[XB-1:0]);
    coord[1] = esp_pkg::COORD_W'(in_item.pixel_y[XB-1:0]);
    coord[2] = in_item.frame_index;
    for (int i = 0; i < 3; i++) begin
      d_next[i] = $signed({1'b0, coord[i], 8'h00}) -
                  $signed({4'b0, cfg.centre[SW*i +: SW]});
    end
    m[0][0] = $signed(cfg.metric_dia[0 +: SW]);
    m[1][1] = $signed(cfg.metric_dia[SW +: SW]);
    m[2][2] = $signed(cfg.metric_dia[2*SW +: SW]);
    m[0][1] = $signed(cfg.metric_crs[0 +: SW]);
    m[1][0] = m[0][1];
    m[0][2] = $signed(cfg.metric_crs[SW +: SW]);
    m[2][0] = m[0][2];
    m[1][2] = $signed(cfg.metric_crs[2*SW +: SW]);
    m[2][1] = m[1][2];
    for (int i = 0; i < 3; i++) begin
      acc[i] = esp_pkg::ACC_W'(prod[3*i]) + esp_pkg::ACC_W'(prod[3*i+1]) +
               esp_pkg::ACC_W'(prod[3*i+2]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1       <= 1'b0;
      v2       <= 1'b0;
      v3       <= 1'b0;
      v4       <= 1'b0;
      rr_valid <= 1'b0;
    end else if (en) begin
      v1       <= in_valid;
      v2       <= v1;
      v3       <= v2;
      v4       <= v3;
      rr_valid <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // stage 1: offset from the centre
      d1  <= d_next;
      mk1 <= in_item.mask_in;
      // stage 2: the nine metric products
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          prod[3*i+j] <= m[i][j] * d1[j];
        end
      end
      d2  <= d1;
      mk2 <= mk1;
      // stage 3: row sums, floored back to Q.8
      for (int i = 0; i < 3; i++) begin
        w3[i] <= acc[i][esp_pkg::ACC_W-1:16];
      end
      d3  <= d2;
      mk3 <= mk2;
      // stage 4: d_i * w_i
      for (int i = 0; i < 3; i++) begin
        q4[i] <= d3[i] * w3[i];
      end
      mk4 <= mk3;
      // stage 5: final sum
      rr      <= esp_pkg::RR_W'(q4[0]) + esp_pkg::RR_W'(q4[1]) + esp_pkg::RR_W'(q4[2]);
      rr_mask <= mk4;
    end
  end

endmodule

// File: rtl/core/esp_class.sv
// Shell classification, mask merge and the output register
`timescale 1ns / 1ps

module esp_class (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             en,
  input  logic                             rr_valid,
  input  logic signed [esp_pkg::RR_W-1:0]  rr,
  input  logic [1:0]                       rr_mask,
  input  esp_pkg::cfg_t                    cfg,
  output logic                             out_valid,
  output esp_pkg::out_item_t               out_item
);

  localparam int PADW = esp_pkg::RR_W - esp_pkg::SQ_W;

  logic signed [esp_pkg::RR_W-1:0] pe2, bb2, be2, one2;
  logic [1:0]                      cls;
  esp_pkg::out_item_t              item_next;

  always_comb begin
    pe2  = $signed({{PADW{1'b0}}, cfg.peak_sq});
    bb2  = $signed({{PADW{1'b0}}, cfg.inner_sq});
    be2  = $signed({{PADW{1'b0}}, cfg.outer_sq});
    one2 = $signed({{PADW{1'b0}}, esp_pkg::FIXED_PEAK_SQ});
    if (cfg.fixed_mode) begin
      if (rr <= one2)      cls = esp_pkg::CLS_PEAK;
      else if (rr <= bb2)  cls = esp_pkg::CLS_FORBIDDEN;
      else if (rr <= be2)  cls = esp_pkg::CLS_BACKGROUND;
      else                 cls = esp_pkg::CLS_EXCLUDED;
    end else begin
      if (rr <= pe2)       cls = esp_pkg::CLS_PEAK;
      else if (rr > be2)   cls = esp_pkg::CLS_EXCLUDED;
      else if (rr >= bb2)  cls = esp_pkg::CLS_BACKGROUND;
      else                 cls = esp_pkg::CLS_FORBIDDEN;
    end

    item_next.region_class = cls;
    item_next.mask_out     = rr_mask;
    item_next.accept       = 1'b0;
    // forbidden in the mask is sticky and blocks integration
    if (rr_mask != esp_pkg::CLS_FORBIDDEN) begin
      if (cls == esp_pkg::CLS_FORBIDDEN || cls == esp_pkg::CLS_PEAK) begin
        item_next.mask_out = cls;
      end else if (cls == esp_pkg::CLS_BACKGROUND && rr_mask == esp_pkg::CLS_EXCLUDED) begin
        item_next.mask_out = esp_pkg::CLS_BACKGROUND;
      end
      item_next.accept = (cls == esp_pkg::CLS_PEAK) ||
                         (cls == esp_pkg::CLS_BACKGROUND &&
                          rr_mask == esp_pkg::CLS_BACKGROUND);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= rr_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_item <= item_next;
    end
  end

endmodule

// File: rtl/core/ellipsoid_shell_pixel_classifier.sv
// Top level of the ellipsoid shell pixel classifier
//
// Input channel in_valid/in_ready/in_data carries one pixel item (x, y,
// frame, current mask code). Output channel out_valid/out_ready/out_data
// returns its class, the merged mask and the integration flag, one result
// per item, in order.
// Configuration: cfg_valid/cfg_ready/cfg_index/cfg_data writes the register
// at cfg_index; cfg_ready is always high and unknown indexes are dropped.
// Write registers only while no item is in flight.
// A result reaches out_data through six register stages: offset,
// metric multiplies, row sums, second multiplies, final sum and the
// classify/output register; the offset stage loads at the accepting edge.
// Throughput: one item per cycle unless the output stalls; every stage
// advances together. When the receiver stalls with a result waiting, the
// whole pipeline holds and in_ready drops; nothing is lost or repeated.
// Reset clears all stage valid bits and loads the register reset values;
// the squared radii follow a radius write in the next cycle.
`timescale 1ns / 1ps

`include "ellipsoid_shell_pixel_classifier_assert.svh"

module ellipsoid_shell_pixel_classifier #(
  parameter int PIXEL_BITS = esp_pkg::PIXEL_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  esp_pkg::in_item_t               in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output esp_pkg::out_item_t              out_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [esp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [esp_pkg::CFG_DATA_W-1:0]  cfg_data
);

  esp_pkg::cfg_t                    cfg;
  logic                             advance;
  logic                             rr_valid;
  logic signed [esp_pkg::RR_W-1:0]  rr;
  logic [1:0]                       rr_mask;

  // advance all pipeline stages unless a result waits on a stalled receiver
  assign advance   = !out_valid || out_ready;
  assign in_ready  = advance;
  assign cfg_ready = 1'b1;

  esp_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  esp_quad #(
    .PIXEL_BITS (PIXEL_BITS)
  ) u_quad (
    .clk      (clk),
    .rst      (rst),
    .en       (advance),
    .in_valid (in_valid),
    .in_item  (in_data),
    .cfg      (cfg),
    .rr_valid (rr_valid),
    .rr       (rr),
    .rr_mask  (rr_mask)
  );

  esp_class u_class (
    .clk       (clk),
    .rst       (rst),
    .en        (advance),
    .rr_valid  (rr_valid),
    .rr        (rr),
    .rr_mask   (rr_mask),
    .cfg       (cfg),
    .out_valid (out_valid),
    .out_item  (out_data)
  );

  `ESP_ASSERT_IMP(a_stall_blocks_input, clk, rst, out_valid && !out_ready, !in_ready, "input taken while output stalled")
  `ESP_ASSERT_IMP(a_accept_mask, clk, rst, out_valid && out_data.accept, out_data.mask_out == esp_pkg::CLS_PEAK || out_data.mask_out == esp_pkg::CLS_BACKGROUND, "accepted pixel with bad mask")
  `ESP_ASSERT_IMP(a_peak_mask, clk, rst, out_valid && out_data.region_class == esp_pkg::CLS_PEAK, out_data.mask_out == esp_pkg::CLS_PEAK || out_data.mask_out == esp_pkg::CLS_FORBIDDEN, "peak class not merged")

endmodule

// File: verif/tb_ellipsoid_shell_pixel_classifier.sv
// Self-checking testbench for the ellipsoid shell pixel classifier
`timescale 1ns / 1ps

module tb_ellipsoid_shell_pixel_classifier;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int RAND_ITEMS  = 1950;
  localparam int LONG_HOLD   = 300;
  localparam int Q16_ONE     = 65536;
  localparam int MAX_LINES   = 50;
  localparam int SW          = esp_pkg::SLICE_W;
  localparam logic [esp_pkg::CFG_IDX_W-1:0] REG_UNMAPPED = 3'd7;

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           in_valid = 1'b0;
  logic                           in_ready;
  esp_pkg::in_item_t              in_data = '0;
  logic                           out_valid;
  logic                           out_ready = 1'b0;
  esp_pkg::out_item_t             out_data;
  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [esp_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [esp_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  // register image used by the predictor
  logic [esp_pkg::REG_W-1:0] cfg_centre = '0;
  logic [esp_pkg::REG_W-1:0] cfg_dia = '0;
  logic [esp_pkg::REG_W-1:0] cfg_crs = '0;
  logic [esp_pkg::RAD_W-1:0] cfg_peak = esp_pkg::PEAK_RST;
  logic [esp_pkg::RAD_W-1:0] cfg_inner = esp_pkg::INNER_RST;
  logic [esp_pkg::RAD_W-1:0] cfg_outer = esp_pkg::OUTER_RST;
  logic                      cfg_fixed = 1'b0;

  esp_pkg::in_item_t  pixel_q[$];
  esp_pkg::out_item_t verdict_q[$];
  esp_pkg::out_item_t want;
  int        mismatch_cnt = 0;
  int        verdict_cnt = 0;
  int        cycle_cnt = 0;
  int        tx_wait = 0;
  int        rx_wait = 0;
  bit        no_idle = 1'b0;
  bit        rx_hold_req = 1'b0;

  ellipsoid_shell_pixel_classifier DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic longint metric_at(logic [esp_pkg::REG_W-1:0] word, int k);
    return longint'($signed(word[SW*k +: SW]));
  endfunction

  function automatic logic [esp_pkg::REG_W-1:0] pack3(int a, int b, int c);
    return {SW'(c), SW'(b), SW'(a)};
  endfunction

  function automatic esp_pkg::out_item_t classify_pixel(esp_pkg::in_item_t px);
    longint    d[3];
    longint    w[3];
    longint    m[3][3];
    longint    rr;
    longint    row;
    longint    pk2;
    longint    in2;
    longint    out2;
    logic [1:0] cls;
    logic [1:0] mo;
    esp_pkg::out_item_t res;
    d[0] = longint'(px.pixel_x) * 256 - longint'(cfg_centre[0 +: SW]);
    d[1] = longint'(px.pixel_y) * 256 - longint'(cfg_centre[SW +: SW]);
    d[2] = longint'(px.frame_index) * 256 - longint'(cfg_centre[2*SW +: SW]);
    for (int i = 0; i < 3; i++) m[i][i] = metric_at(cfg_dia, i);
    m[0][1] = metric_at(cfg_crs, 0);
    m[0][2] = metric_at(cfg_crs, 1);
    m[1][2] = metric_at(cfg_crs, 2);
    m[1][0] = m[0][1];
    m[2][0] = m[0][2];
    m[2][1] = m[1][2];
    rr = 0;
    for (int i = 0; i < 3; i++) begin
      row = 0;
      for (int j = 0; j < 3; j++) row += m[i][j] * d[j];
      // arithmetic shift floors toward minus infinity
      w[i] = row >>> 16;
    end
    for (int i = 0; i < 3; i++) rr += d[i] * w[i];
    pk2 = longint'(cfg_peak) * longint'(cfg_peak);
    in2 = longint'(cfg_inner) * longint'(cfg_inner);
    out2 = longint'(cfg_outer) * longint'(cfg_outer);
    if (cfg_fixed) begin
      if (rr <= longint'(esp_pkg::FIXED_PEAK_SQ)) cls = esp_pkg::CLS_PEAK;
      else if (rr <= in2) cls = esp_pkg::CLS_FORBIDDEN;
      else if (rr <= out2) cls = esp_pkg::CLS_BACKGROUND;
      else cls = esp_pkg::CLS_EXCLUDED;
    end else begin
      if (rr <= pk2) cls = esp_pkg::CLS_PEAK;
      else if (rr > out2) cls = esp_pkg::CLS_EXCLUDED;
      else if (rr >= in2) cls = esp_pkg::CLS_BACKGROUND;
      else cls = esp_pkg::CLS_FORBIDDEN;
    end
    mo = px.mask_in;
    if (px.mask_in != esp_pkg::CLS_FORBIDDEN) begin
      if (cls == esp_pkg::CLS_FORBIDDEN || cls == esp_pkg::CLS_PEAK) mo = cls;
      else if (cls == esp_pkg::CLS_BACKGROUND && px.mask_in == esp_pkg::CLS_EXCLUDED)
        mo = esp_pkg::CLS_BACKGROUND;
    end
    res.region_class = cls;
    res.mask_out = mo;
    res.accept = (px.mask_in != esp_pkg::CLS_FORBIDDEN) &&
                 (cls == esp_pkg::CLS_PEAK ||
                  (cls == esp_pkg::CLS_BACKGROUND &&
                   px.mask_in == esp_pkg::CLS_BACKGROUND));
    return res;
  endfunction

  function automatic int idle_len();
    int r;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic int offset_in(int span);
    return int'($urandom_range(2 * span)) - span;
  endfunction

  task automatic report_mismatch(string what, int got, int exp_val);
    if (mismatch_cnt < MAX_LINES)
      $display("mismatch on result %0d, %s: got %0d, expected %0d",
               verdict_cnt, what, got, exp_val);
    mismatch_cnt++;
  endtask

  // sender: offer pixel items, predict on acceptance
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      tx_wait = 0;
    end else begin
      if (in_valid && in_ready) verdict_q.push_back(classify_pixel(in_data));
      if (!in_valid || in_ready) begin
        if (tx_wait > 0) begin
          tx_wait--;
          in_valid <= 1'b0;
        end else if (pixel_q.size() != 0) begin
          in_data <= pixel_q.pop_front();
          in_valid <= 1'b1;
          if (!no_idle) tx_wait = idle_len();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: check results in order, stall at random
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      rx_wait = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (verdict_q.size() == 0) begin
          report_mismatch("result with nothing pending", int'(out_data), -1);
        end else begin
          want = verdict_q.pop_front();
          if (out_data.region_class !== want.region_class)
            report_mismatch("region_class", int'(out_data.region_class),
                            int'(want.region_class));
          if (out_data.mask_out !== want.mask_out)
            report_mismatch("mask_out", int'(out_data.mask_out), int'(want.mask_out));
          if (out_data.accept !== want.accept)
            report_mismatch("accept", int'(out_data.accept), int'(want.accept));
        end
        verdict_cnt++;
      end
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        rx_wait = LONG_HOLD;
      end
      if (rx_wait > 0) begin
        rx_wait--;
        out_ready <= 1'b0;
      end else if (no_idle || $urandom_range(99) < 70) begin
        out_ready <= 1'b1;
      end else begin
        rx_wait = idle_len();
        out_ready <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic wait_drained();
    while (pixel_q.size() != 0 || in_valid || verdict_q.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  // call at a rising edge; leaves cfg_valid high for a following write
  task automatic write_reg(logic [esp_pkg::CFG_IDX_W-1:0] idx,
                           logic [esp_pkg::CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      esp_pkg::REG_CENTRE:     cfg_centre = val[esp_pkg::REG_W-1:0];
      esp_pkg::REG_METRIC_DIA: cfg_dia = val[esp_pkg::REG_W-1:0];
      esp_pkg::REG_METRIC_CRS: cfg_crs = val[esp_pkg::REG_W-1:0];
      esp_pkg::REG_PEAK_RAD:   cfg_peak = val[esp_pkg::RAD_W-1:0];
      esp_pkg::REG_INNER_RAD:  cfg_inner = val[esp_pkg::RAD_W-1:0];
      esp_pkg::REG_OUTER_RAD:  cfg_outer = val[esp_pkg::RAD_W-1:0];
      esp_pkg::REG_FIXED_MODE: cfg_fixed = val[0];
      default: ;
    endcase
  endtask

  task automatic set_config(logic [esp_pkg::REG_W-1:0] centre,
                            logic [esp_pkg::REG_W-1:0] dia,
                            logic [esp_pkg::REG_W-1:0] crs,
                            logic [esp_pkg::RAD_W-1:0] peak,
                            logic [esp_pkg::RAD_W-1:0] inner,
                            logic [esp_pkg::RAD_W-1:0] outer,
                            logic fixed, bit junk,
                            logic [esp_pkg::CFG_DATA_W-1:0] junk_val);
    wait_drained();
    @(posedge clk);
    write_reg(esp_pkg::REG_CENTRE, esp_pkg::CFG_DATA_W'(centre));
    write_reg(esp_pkg::REG_METRIC_DIA, esp_pkg::CFG_DATA_W'(dia));
    write_reg(esp_pkg::REG_METRIC_CRS, esp_pkg::CFG_DATA_W'(crs));
    write_reg(esp_pkg::REG_PEAK_RAD, esp_pkg::CFG_DATA_W'(peak));
    write_reg(esp_pkg::REG_INNER_RAD, esp_pkg::CFG_DATA_W'(inner));
    write_reg(esp_pkg::REG_OUTER_RAD, esp_pkg::CFG_DATA_W'(outer));
    write_reg(esp_pkg::REG_FIXED_MODE, esp_pkg::CFG_DATA_W'(fixed));
    // an unmapped write last, so any aliasing would corrupt a live register
    if (junk) write_reg(REG_UNMAPPED, junk_val);
    cfg_valid <= 1'b0;
    // squared radii follow a radius write in the next cycle
    repeat (3) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic add_pixel(int x, int y, int f, logic [1:0] mask);
    esp_pkg::in_item_t px;
    px.pixel_x = esp_pkg::PIX_W'(x);
    px.pixel_y = esp_pkg::PIX_W'(y);
    px.frame_index = esp_pkg::FRAME_W'(f);
    px.mask_in = mask;
    pixel_q.push_back(px);
  endtask

  initial begin : stimulus
    logic [esp_pkg::REG_W-1:0] centre;
    logic [esp_pkg::REG_W-1:0] dia;
    logic [esp_pkg::REG_W-1:0] crs;
    logic [esp_pkg::RAD_W-1:0] peak;
    logic [esp_pkg::RAD_W-1:0] inner;
    logic [esp_pkg::RAD_W-1:0] outer;
    int               dv[3];
    int               cv[3];
    int               cx;
    int               cy;
    int               cf;
    int               span;
    int               pspan;
    int               s;
    int               n;
    int               rand_items;
    bit               first;
    logic [63:0]      all_ones;

    all_ones = '1;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset values: zero metric puts every pixel in the peak
    add_pixel(0, 0, 0, esp_pkg::CLS_EXCLUDED);
    add_pixel(8191, 8191, 65535, esp_pkg::CLS_BACKGROUND);
    add_pixel(4096, 1, 32768, esp_pkg::CLS_FORBIDDEN);
    add_pixel(1, 4096, 1, esp_pkg::CLS_PEAK);

    // reset values again, then an unmapped write that must change nothing
    set_config('0, '0, '0, esp_pkg::PEAK_RST, esp_pkg::INNER_RST, esp_pkg::OUTER_RST,
               1'b0, 1'b1, all_ones);
    add_pixel(77, 3000, 500, esp_pkg::CLS_EXCLUDED);

    // unit metric, variable rules: peak 2, shell 3..5 pixels
    centre = pack3(100 * 256, 100 * 256, 50 * 256);
    dia = pack3(Q16_ONE, Q16_ONE, Q16_ONE);
    set_config(centre, dia, '0, 16'd512, 16'd768, 16'd1280, 1'b0, 1'b0, '0);
    add_pixel(100, 100, 50, esp_pkg::CLS_EXCLUDED);
    add_pixel(102, 100, 50, esp_pkg::CLS_BACKGROUND);   // on the peak radius
    add_pixel(101, 102, 50, esp_pkg::CLS_FORBIDDEN);    // forbidden stays sticky
    add_pixel(103, 100, 50, esp_pkg::CLS_EXCLUDED);     // on the inner radius
    add_pixel(100, 95, 50, esp_pkg::CLS_BACKGROUND);    // on the outer radius
    add_pixel(105, 101, 50, esp_pkg::CLS_PEAK);         // just outside

    // fixed rules: unit peak, inclusive bounds
    set_config(centre, dia, '0, 16'd512, 16'd768, 16'd1280, 1'b1, 1'b0, '0);
    add_pixel(101, 100, 50, esp_pkg::CLS_EXCLUDED);
    add_pixel(101, 101, 50, esp_pkg::CLS_BACKGROUND);
    add_pixel(100, 100, 53, esp_pkg::CLS_PEAK);
    add_pixel(104, 100, 50, esp_pkg::CLS_EXCLUDED);
    add_pixel(100, 105, 50, esp_pkg::CLS_BACKGROUND);
    add_pixel(100, 100, 56, esp_pkg::CLS_PEAK);

    // indefinite metric: negative rr
    dia = pack3(-Q16_ONE, Q16_ONE, Q16_ONE);
    set_config(centre, dia, '0, 16'd512, 16'd768, 16'd1280, 1'b0, 1'b0, '0);
    add_pixel(103, 100, 50, esp_pkg::CLS_BACKGROUND);
    add_pixel(103, 101, 50, esp_pkg::CLS_EXCLUDED);
    add_pixel(100, 103, 50, esp_pkg::CLS_BACKGROUND);

    // extremes of registers and fields
    dia = pack3(1048575, 1048575, 1048575);
    set_config('0, dia, dia, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 1'b0, '0);
    add_pixel(8191, 8191, 65535, esp_pkg::CLS_EXCLUDED);
    add_pixel(0, 0, 0, esp_pkg::CLS_FORBIDDEN);
    dia = pack3(-1048576, -1048576, -1048576);
    set_config('1, dia, dia, '0, '0, '0, 1'b0, 1'b0, '0);
    add_pixel(0, 0, 0, esp_pkg::CLS_PEAK);
    add_pixel(8191, 8191, 65535, esp_pkg::CLS_BACKGROUND);

    rand_items = 0;
    first = 1'b1;
    while (rand_items < RAND_ITEMS) begin
      if ($urandom_range(9) == 0) centre = $urandom_range(1) ? '0 : '1;
      else centre = esp_pkg::REG_W'({$urandom, $urandom});
      if ($urandom_range(9) == 0) begin
        dia = esp_pkg::REG_W'({$urandom, $urandom});
        crs = esp_pkg::REG_W'({$urandom, $urandom});
      end else begin
        for (int k = 0; k < 3; k++) begin
          dv[k] = $urandom_range(16384, 262144);
          if ($urandom_range(6) == 0) dv[k] = -dv[k];
          cv[k] = int'($urandom_range(32768)) - 16384;
        end
        dia = pack3(dv[0], dv[1], dv[2]);
        crs = pack3(cv[0], cv[1], cv[2]);
      end
      peak = esp_pkg::RAD_W'($urandom_range(1536));
      if ($urandom_range(4) == 0) inner = esp_pkg::RAD_W'($urandom_range(2048));
      else inner = peak + esp_pkg::RAD_W'($urandom_range(768));
      outer = inner + esp_pkg::RAD_W'($urandom_range(1536));
      case ($urandom_range(19))
        0: begin peak = '0; inner = '0; outer = '0; end
        1: begin peak = '1; inner = '1; outer = '1; end
        2: outer = '1;
        default: ;
      endcase
      set_config(centre, dia, crs, peak, inner, outer, 1'($urandom_range(1)),
                 $urandom_range(4) == 0, {$urandom, $urandom});

      no_idle = ($urandom_range(3) == 0);
      if (first) begin
        // keep offering while the receiver holds off, so the pipeline backs up
        no_idle = 1'b1;
        rx_hold_req = 1'b1;
        first = 1'b0;
      end
      cx = int'(centre[20:8]);
      cy = int'(centre[41:29]);
      cf = int'(centre[62:50]);
      span = (int'(outer) >> 7) + 3;
      if (span > 40) span = 40;
      pspan = (int'(peak) >> 8) + 1;
      if (pspan > 40) pspan = 40;
      n = $urandom_range(40, 160);
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(9) == 0) begin
          add_pixel($urandom, $urandom, $urandom, 2'($urandom_range(3)));
        end else begin
          s = ($urandom_range(2) == 0) ? pspan : span;
          add_pixel(cx + offset_in(s), cy + offset_in(s), cf + offset_in(s),
                    2'($urandom_range(3)));
        end
      end
      rand_items += n;
    end

    wait_drained();
    repeat (20) @(posedge clk);
    if (mismatch_cnt == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule

// File: files.f
+incdir+rtl/core
rtl/core/esp_pkg.sv
rtl/core/esp_cfg.sv
rtl/core/esp_quad.sv
rtl/core/esp_class.sv
rtl/core/ellipsoid_shell_pixel_classifier.sv
verif/tb_ellipsoid_shell_pixel_classifier.sv
